FILE: design/stnd_pkg.sv
// Shared types, register map and field constants of the strided address generator.
package stnd_pkg;

  localparam int NUM_INPUTS = 4;
  localparam int NUM_DESC   = 4;
  localparam int FIELD_W    = 16;
  localparam int ELEM_W     = 13;
  localparam int DESC_W     = 48;
  localparam int BASE_W     = 48;
  localparam int OUT_W      = 48;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int NDIMS_W    = 3;

  localparam int EXT_LSB    = 0;
  localparam int STRIDE_LSB = 16;
  localparam int PITCH_LSB  = 32;

  typedef logic [DESC_W-1:0]  desc_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [2:0] {
    REG_BASE,
    REG_ELEM_SIZE,
    REG_ROW_ORDER,
    REG_NUM_DIMS,
    REG_DIM0,
    REG_DIM1,
    REG_DIM2,
    REG_DIM3
  } reg_idx_t;

  function automatic field_t desc_extent(input desc_t d);
    return d[EXT_LSB +: FIELD_W];
  endfunction

  function automatic field_t desc_stride(input desc_t d);
    return d[STRIDE_LSB +: FIELD_W];
  endfunction

  function automatic field_t desc_pitch(input desc_t d);
    return d[PITCH_LSB +: FIELD_W];
  endfunction

endpackage

FILE: design/stnd_step_seq.sv
// Byte step sequencer: walks the dimensions after a configuration write and fills the lane tables.
module stnd_step_seq #(
  parameter int MAX_DIMS  = 4,
  parameter int ADDR_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [stnd_pkg::ELEM_W-1:0]  elem_bytes,
  input  logic                         row_order,
  input  logic [stnd_pkg::NDIMS_W-1:0] num_dims,
  input  stnd_pkg::desc_t              desc [MAX_DIMS],
  output logic                         busy,
  output logic [ADDR_BITS-1:0]         lane_step [MAX_DIMS],
  output stnd_pkg::field_t             lane_ext [MAX_DIMS],
  output logic [MAX_DIMS-1:0]          lane_en
);

  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PROD_W = ADDR_BITS + stnd_pkg::FIELD_W;
  localparam logic [3:0] MAX_N = 4'(MAX_DIMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RUN
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       idx_r;
  logic [ADDR_BITS-1:0]   cp_r;
  logic [ADDR_BITS-1:0]   lane_step_r [MAX_DIMS];
  stnd_pkg::field_t       lane_ext_r [MAX_DIMS];
  logic [MAX_DIMS-1:0]    lane_en_r;

  logic [3:0]             nd;
  logic [3:0]             n_used;
  logic [3:0]             idx_ext;
  logic [3:0]             pos;
  stnd_pkg::desc_t        cur;
  logic [PROD_W-1:0]      step_prod;
  logic [PROD_W-1:0]      cp_prod;

  always_comb begin
    nd = {1'b0, num_dims};
    if (nd == 4'd0) begin
      n_used = 4'd1;
    end else if (nd > MAX_N) begin
      n_used = MAX_N;
    end else begin
      n_used = nd;
    end
    idx_ext   = 4'(idx_r);
    // row order: the outermost dimension lands in the first lane
    pos       = row_order ? (n_used - 4'd1 - idx_ext) : idx_ext;
    cur       = desc[idx_r];
    step_prod = PROD_W'(cp_r) * PROD_W'(stnd_pkg::desc_stride(cur));
    cp_prod   = PROD_W'(cp_r) * PROD_W'(stnd_pkg::desc_pitch(cur));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      cp_r      <= '0;
      lane_en_r <= MAX_DIMS'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        lane_step_r[d] <= '0;
        lane_ext_r[d]  <= '0;
      end
    end else if (restart) begin
      state_r <= S_LOAD;
    end else begin
      case (state_r)
        S_IDLE: begin
        end
        S_LOAD: begin
          cp_r      <= ADDR_BITS'(elem_bytes);
          idx_r     <= '0;
          lane_en_r <= '0;
          state_r   <= S_RUN;
        end
        S_RUN: begin
          lane_step_r[pos[IDX_W-1:0]] <= step_prod[ADDR_BITS-1:0];
          lane_ext_r[pos[IDX_W-1:0]]  <= stnd_pkg::desc_extent(cur);
          lane_en_r[pos[IDX_W-1:0]]   <= 1'b1;
          cp_r                        <= cp_prod[ADDR_BITS-1:0];
          if (idx_ext == n_used - 4'd1) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign lane_step = lane_step_r;
  assign lane_ext  = lane_ext_r;
  assign lane_en   = lane_en_r;

endmodule

FILE: design/stnd_lane.sv
// One address lane: coordinate times byte step, and the extent check.
module stnd_lane #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 48
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [COORD_BITS-1:0]  coord,
  input  logic [ADDR_BITS-1:0]   step,
  input  stnd_pkg::field_t       ext,
  input  logic                   en,
  output logic [ADDR_BITS-1:0]   prod_r,
  output logic                   oor_r
);

  localparam int PROD_W = COORD_BITS + ADDR_BITS;
  localparam int CMP_W  = (COORD_BITS > stnd_pkg::FIELD_W) ? COORD_BITS : stnd_pkg::FIELD_W;

  logic [PROD_W-1:0] prod_full;
  logic [ADDR_BITS-1:0] prod_nxt;
  logic oor_nxt;

  always_comb begin
    prod_full = PROD_W'(coord) * PROD_W'(step);
    prod_nxt  = en ? prod_full[ADDR_BITS-1:0] : '0;
    oor_nxt   = en && (CMP_W'(coord) >= CMP_W'(ext));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      oor_r  <= oor_nxt;
    end
  end

endmodule

FILE: design/stnd_merge.sv
// Merge stage: base plus the lane products, and the combined range flag.
module stnd_merge #(
  parameter int MAX_DIMS  = 4,
  parameter int ADDR_BITS = 48
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [ADDR_BITS-1:0]  base,
  input  logic [ADDR_BITS-1:0]  prod [MAX_DIMS],
  input  logic [MAX_DIMS-1:0]   oor,
  output logic [ADDR_BITS-1:0]  address_r,
  output logic                  oor_r
);

  localparam int OUT_KEEP = (ADDR_BITS < stnd_pkg::OUT_W) ? ADDR_BITS : stnd_pkg::OUT_W;
  localparam logic [ADDR_BITS-1:0] OUT_MASK = ADDR_BITS'((65'(1) << OUT_KEEP) - 65'(1));

  logic [ADDR_BITS-1:0] sum;
  logic [ADDR_BITS-1:0] address_nxt;

  always_comb begin
    sum = base;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum = sum + prod[d];
    end
    address_nxt = sum & OUT_MASK;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      address_r <= address_nxt;
      oor_r     <= |oor;
    end
  end

endmodule

FILE: design/strided_nd_address_generator_unit.sv
// Two stages, the lane stage and the output stage, lie between an accepted item and its result.
// One item per cycle with out_ready high and busy low; a full output stage keeps taking items.
// After each register write the step sequencer runs a load step and then one multiply pair
// per used dimension; in_ready is low while it runs.
// Reset (synchronous, rst_n low) restores the reset registers and zero steps; no item is held.
module strided_nd_address_generator_unit #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_BITS-1:0]            in_coord0,
  input  logic [COORD_BITS-1:0]            in_coord1,
  input  logic [COORD_BITS-1:0]            in_coord2,
  input  logic [COORD_BITS-1:0]            in_coord3,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ADDR_BITS-1:0]             out_address,
  output logic                             out_out_of_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stnd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [stnd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [stnd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // configuration registers
  logic [stnd_pkg::BASE_W-1:0]   base_r;
  logic [stnd_pkg::ELEM_W-1:0]   elem_r;
  logic                          row_r;
  logic [stnd_pkg::NDIMS_W-1:0]  ndims_r;
  stnd_pkg::desc_t               desc_r [MAX_DIMS];
  stnd_pkg::desc_t               desc_pad [stnd_pkg::NUM_DESC];

  logic                          cfg_wr;
  stnd_pkg::reg_idx_t            cfg_idx;

  // step tables and pipeline control
  logic                          busy;
  logic [ADDR_BITS-1:0]          lane_step [MAX_DIMS];
  stnd_pkg::field_t              lane_ext [MAX_DIMS];
  logic [MAX_DIMS-1:0]           lane_en;

  logic [COORD_BITS-1:0]         coord_a [stnd_pkg::NUM_INPUTS];
  logic [COORD_BITS-1:0]         lane_coord [MAX_DIMS];
  logic [ADDR_BITS-1:0]          lane_prod [MAX_DIMS];
  logic [MAX_DIMS-1:0]           lane_oor;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_load;
  logic                          s1_load;
  logic [63:0]                   base_wide;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = stnd_pkg::reg_idx_t'(paddr[stnd_pkg::CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      elem_r  <= stnd_pkg::ELEM_W'(1);
      row_r   <= 1'b0;
      ndims_r <= stnd_pkg::NDIMS_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        stnd_pkg::REG_BASE:      base_r  <= pwdata[stnd_pkg::BASE_W-1:0];
        stnd_pkg::REG_ELEM_SIZE: elem_r  <= pwdata[stnd_pkg::ELEM_W-1:0];
        stnd_pkg::REG_ROW_ORDER: row_r   <= pwdata[0];
        stnd_pkg::REG_NUM_DIMS:  ndims_r <= pwdata[stnd_pkg::NDIMS_W-1:0];
        default: begin
          // descriptors are written per dimension below
        end
      endcase
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_desc
    if (d < stnd_pkg::NUM_DESC) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          desc_r[d] <= '0;
        end else if (cfg_wr && (cfg_idx == stnd_pkg::reg_idx_t'(int'(stnd_pkg::REG_DIM0) + d))) begin
          desc_r[d] <= pwdata[stnd_pkg::DESC_W-1:0];
        end
      end
    end else begin : g_none
      // no register reaches this dimension: extent, stride and pitch stay zero
      assign desc_r[d] = '0;
    end
  end

  for (genvar d = 0; d < stnd_pkg::NUM_DESC; d++) begin : g_pad
    if (d < MAX_DIMS) begin : g_have
      assign desc_pad[d] = desc_r[d];
    end else begin : g_zero
      assign desc_pad[d] = '0;
    end
  end

  always_comb begin
    case (cfg_idx)
      stnd_pkg::REG_BASE:      prdata = stnd_pkg::CFG_DATA_W'(base_r);
      stnd_pkg::REG_ELEM_SIZE: prdata = stnd_pkg::CFG_DATA_W'(elem_r);
      stnd_pkg::REG_ROW_ORDER: prdata = stnd_pkg::CFG_DATA_W'(row_r);
      stnd_pkg::REG_NUM_DIMS:  prdata = stnd_pkg::CFG_DATA_W'(ndims_r);
      stnd_pkg::REG_DIM0:      prdata = stnd_pkg::CFG_DATA_W'(desc_pad[0]);
      stnd_pkg::REG_DIM1:      prdata = stnd_pkg::CFG_DATA_W'(desc_pad[1]);
      stnd_pkg::REG_DIM2:      prdata = stnd_pkg::CFG_DATA_W'(desc_pad[2]);
      stnd_pkg::REG_DIM3:      prdata = stnd_pkg::CFG_DATA_W'(desc_pad[3]);
      default:                 prdata = '0;
    endcase
  end

  stnd_step_seq #(
    .MAX_DIMS  (MAX_DIMS),
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_wr),
    .elem_bytes   (elem_r),
    .row_order    (row_r),
    .num_dims     (ndims_r),
    .desc         (desc_r),
    .busy         (busy),
    .lane_step    (lane_step),
    .lane_ext     (lane_ext),
    .lane_en      (lane_en)
  );

  // handshake: the output stage frees the lane stage, which frees the input
  always_comb begin
    out_load = !out_valid_r || out_ready;
    in_ready = !busy && (!s1_valid_r || out_load);
    s1_load  = in_valid && in_ready;

    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign coord_a[0] = in_coord0;
  assign coord_a[1] = in_coord1;
  assign coord_a[2] = in_coord2;
  assign coord_a[3] = in_coord3;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    if (i < stnd_pkg::NUM_INPUTS) begin : g_in
      assign lane_coord[i] = coord_a[i];
    end else begin : g_zero
      assign lane_coord[i] = '0;
    end

    stnd_lane #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (s1_load),
      .coord  (lane_coord[i]),
      .step   (lane_step[i]),
      .ext    (lane_ext[i]),
      .en     (lane_en[i]),
      .prod_r (lane_prod[i]),
      .oor_r  (lane_oor[i])
    );
  end

  assign base_wide = 64'(base_r);

  stnd_merge #(
    .MAX_DIMS  (MAX_DIMS),
    .ADDR_BITS (ADDR_BITS)
  ) u_merge (
    .clk       (clk),
    .load      (out_load && s1_valid_r),
    .base      (base_wide[ADDR_BITS-1:0]),
    .prod      (lane_prod),
    .oor       (lane_oor),
    .address_r (out_address),
    .oor_r     (out_out_of_range)
  );

  assign out_valid = out_valid_r;

  // a register write holds off items until the steps are rebuilt
  a_wr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready)
    else $error("item accepted while steps are being rebuilt");

  // an accepted item reaches the lane stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r)
    else $error("accepted item lost before the lane stage");

  // a lane-stage item that cannot move on is kept
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("stalled lane-stage item dropped");

  // a lane-stage item that moves on becomes the result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_load) |=> out_valid_r)
    else $error("lane-stage item did not reach the output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r && !busy))
    else $error("pipeline not empty after reset");

endmodule
